@@ hw/rtl/minv4_pkg.sv @@
// minv4_pkg: shared constants, sequencer state type and index helpers for the
// 4x4 adjugate matrix inverse
// no dependencies
package minv4_pkg;

	localparam int unsigned ELEM_COUNT = 16;
	localparam int unsigned ELEM_AW    = 4;

	// sequencer states, one-hot
	typedef enum logic [16:0] {
		S_LOAD = 17'b00000000000000001,
		S_RD_A = 17'b00000000000000010,
		S_RD_B = 17'b00000000000000100,
		S_RD_C = 17'b00000000000001000,
		S_MUL1 = 17'b00000000000010000,
		S_MUL2 = 17'b00000000000100000,
		S_ACC  = 17'b00000000001000000,
		S_COF  = 17'b00000000010000000,
		S_DRD  = 17'b00000000100000000,
		S_DLD  = 17'b00000001000000000,
		S_DMUL = 17'b00000010000000000,
		S_DACC = 17'b00000100000000000,
		S_DET  = 17'b00001000000000000,
		S_ORD  = 17'b00010000000000000,
		S_DSET = 17'b00100000000000000,
		S_DIV  = 17'b01000000000000000,
		S_OUT  = 17'b10000000000000000
	} minv4_state_t;

	// n-th of the three indices 0..3 that remain when skip is removed
	function automatic logic [1:0] skip_idx(input logic [1:0] n, input logic [1:0] skip);
		return (n < skip) ? n : n + 2'd1;
	endfunction

	// minor column used by a row of one of the six 3x3 triple-product terms;
	// terms 0..2 are added, terms 3..5 subtracted
	function automatic logic [1:0] term_col(input logic [2:0] term, input logic [1:0] row);
		logic [5:0] cols;
		case (term)
			3'd0:    cols = {2'd2, 2'd1, 2'd0};
			3'd1:    cols = {2'd0, 2'd2, 2'd1};
			3'd2:    cols = {2'd1, 2'd0, 2'd2};
			3'd3:    cols = {2'd0, 2'd1, 2'd2};
			3'd4:    cols = {2'd1, 2'd2, 2'd0};
			3'd5:    cols = {2'd2, 2'd0, 2'd1};
			default: cols = '0;
		endcase
		case (row)
			2'd0:    return cols[1:0];
			2'd1:    return cols[3:2];
			default: return cols[5:4];
		endcase
	endfunction

endpackage

@@ hw/rtl/minv4_ram.sv @@
// minv4_ram: generic single-write, single-read memory with registered read
// no dependencies
module minv4_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hw/rtl/matrix_inverse_4x4.sv @@
// matrix_inverse_4x4: 4x4 fixed-point matrix inverse by the adjugate
// depends on minv4_pkg and minv4_ram
//
// channel  | handshake                    | payload
// ---------+------------------------------+--------------------------------------------
// element  | element_valid, element_ready | element_value
// result   | result_valid, result_ready   | inverse_value, det_value, singular, last
//
// sixteen element transfers fill the matrix memory, one per cycle while loading.
// then one shared multiplier computes sixteen cofactors, each as six triple
// products (read a, b and c, multiply twice, accumulate) and a write step, and
// the determinant along row 0 by a read, load, multiply and accumulate after
// each row-0 cofactor and a final saturate step; each result then takes a
// bit-serial divide of DATA_WIDTH+FRAC_BITS quotient bits, skipped if singular.
// the result register lets the next matrix load while the last result waits.
// reset clears the sequencer and element counter; the memories need no clear.
module matrix_inverse_4x4 #(
	parameter int unsigned FRAC_BITS  = 16,
	parameter int unsigned DATA_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               element_valid,
	output logic               element_ready,
	input  logic signed [31:0] element_value,
	output logic               result_valid,
	input  logic               result_ready,
	output logic signed [31:0] inverse_value,
	output logic signed [31:0] det_value,
	output logic               singular,
	output logic               last
);

	import minv4_pkg::*;

	localparam int unsigned DW = DATA_WIDTH;
	localparam int unsigned PW = 2 * DATA_WIDTH;        // full product
	localparam int unsigned AW = DATA_WIDTH + 4;        // cofactor accumulator
	localparam int unsigned EW = DATA_WIDTH + 3;        // determinant accumulator
	localparam int unsigned NW = DATA_WIDTH + FRAC_BITS; // divide quotient bits
	localparam int unsigned CW = $clog2(NW);

	localparam logic signed [63:0] DMAX = (64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1;
	localparam logic signed [63:0] DMIN = -DMAX - 64'sd1;
	localparam logic signed [63:0] WMAX = 64'sh7fffffff;
	localparam logic signed [63:0] WMIN = -WMAX - 64'sd1;
	localparam logic [PW-1:0] QCAP_POS = (PW'(1) << (DATA_WIDTH - 1)) - PW'(1);
	localparam logic [PW-1:0] QCAP_NEG = PW'(1) << (DATA_WIDTH - 1);
	localparam logic [NW-1:0] DCAP_POS = NW'(32'h7fffffff);
	localparam logic [NW-1:0] DCAP_NEG = NW'(32'h80000000);

	// saturate to the datapath width
	function automatic logic [DW-1:0] sat_dw(input logic signed [63:0] v);
		logic signed [63:0] r;
		r = (v > DMAX) ? DMAX : ((v < DMIN) ? DMIN : v);
		return r[DW-1:0];
	endfunction

	// saturate to the 32-bit port width
	function automatic logic [31:0] sat_32(input logic signed [63:0] v);
		logic signed [63:0] r;
		r = (v > WMAX) ? WMAX : ((v < WMIN) ? WMIN : v);
		return r[31:0];
	endfunction

	// fixed-point multiply, magnitude truncated, saturated
	function automatic logic [DW-1:0] qmul(input logic [DW-1:0] a, input logic [DW-1:0] b);
		logic signed [PW-1:0] prod;
		logic [PW-1:0]        mag;
		logic [PW-1:0]        cap;
		logic                 neg;
		prod = $signed(a) * $signed(b);
		neg  = a[DW-1] ^ b[DW-1];
		mag  = prod[PW-1] ? PW'(-prod) : PW'(prod);
		mag  = mag >> FRAC_BITS;
		cap  = neg ? QCAP_NEG : QCAP_POS;
		if (mag > cap) begin
			mag = cap;
		end
		return neg ? DW'(-mag[DW-1:0]) : mag[DW-1:0];
	endfunction

	function automatic logic signed [63:0] element_sext(input logic [31:0] v);
		return 64'($signed(v));
	endfunction

	minv4_state_t state_q;

	logic [ELEM_AW-1:0] count_q;
	logic [1:0]         row_q;
	logic [1:0]         col_q;
	logic [2:0]         term_q;
	logic [ELEM_AW-1:0] out_k_q;

	logic [DW-1:0]        x_q, y_q, z_q, p_q, cof_q;
	logic signed [AW-1:0] acc_q;
	logic signed [EW-1:0] det_acc_q;
	logic [DW-1:0]        det_q;
	logic [DW-1:0]        ud_q;
	logic                 sing_q;

	logic [NW-1:0] num_q;
	logic [NW-1:0] quo_q;
	logic [DW:0]   rem_q;
	logic          neg_q;
	logic [CW-1:0] div_cnt_q;

	logic               res_valid_q;
	logic [31:0]        inv_q, det32_q;
	logic               sing_out_q, last_q;

	// matrix memory ports
	logic               mat_we;
	logic [ELEM_AW-1:0] mat_raddr;
	logic [31:0]        mat_rdata;
	logic [DW-1:0]      mat_elem;

	// cofactor memory ports
	logic               cof_we;
	logic [DW-1:0]      cof_wdata;
	logic [ELEM_AW-1:0] cof_raddr;
	logic [DW-1:0]      cof_rdata;

	logic               in_xfer;
	logic               out_free;
	logic [DW-1:0]      mul_a;
	logic [DW-1:0]      mul_b;
	logic [DW-1:0]      mul_out;
	logic signed [AW-1:0] cof_sum;
	logic [DW:0]        rem_shift;
	logic [DW:0]        rem_sub;
	logic [NW-1:0]      quo_sat;
	logic [DW-1:0]      cof_mag;
	logic [1:0]         minor_row;

	assign element_ready = (state_q == S_LOAD);
	assign in_xfer       = element_valid && element_ready;
	assign out_free      = !res_valid_q || result_ready;

	assign mat_we   = in_xfer;
	assign mat_elem = sat_dw(64'(element_sext(mat_rdata)));

	// minor row for the read being issued in this state
	always_comb begin
		case (state_q)
			S_RD_A:  minor_row = 2'd0;
			S_RD_B:  minor_row = 2'd1;
			default: minor_row = 2'd2;
		endcase
	end

	// matrix read address: row 0 element during the determinant step
	assign mat_raddr = (state_q == S_DRD) ? {2'd0, col_q}
		: {skip_idx(minor_row, row_q), skip_idx(term_col(term_q, minor_row), col_q)};

	// shared multiplier: a*b first, then the partial product by c,
	// or row-0 element by its cofactor
	always_comb begin
		case (state_q)
			S_MUL1: begin
				mul_a = x_q;
				mul_b = y_q;
			end
			S_MUL2: begin
				mul_a = p_q;
				mul_b = z_q;
			end
			default: begin
				mul_a = x_q;
				mul_b = cof_q;
			end
		endcase
	end

	assign mul_out = qmul(mul_a, mul_b);

	// signed cofactor from the exact six-term sum
	assign cof_sum   = (row_q[0] ^ col_q[0]) ? -acc_q : acc_q;
	assign cof_we    = (state_q == S_COF);
	assign cof_wdata = sat_dw(64'(cof_sum));
	// result (i,j) reads cofactor (j,i)
	assign cof_raddr = {out_k_q[1:0], out_k_q[3:2]};
	assign cof_mag   = cof_rdata[DW-1] ? DW'(-cof_rdata) : cof_rdata;

	// restoring divide step
	assign rem_shift = {rem_q[DW-1:0], num_q[NW-1]};
	assign rem_sub   = rem_shift - {1'b0, ud_q};
	assign quo_sat   = (quo_q > (neg_q ? DCAP_NEG : DCAP_POS))
		? (neg_q ? DCAP_NEG : DCAP_POS) : quo_q;

	minv4_ram #(
		.WIDTH(32),
		.DEPTH(ELEM_COUNT)
	) u_mat_ram (
		.clk  (clk),
		.we   (mat_we),
		.waddr(count_q),
		.wdata(element_value),
		.raddr(mat_raddr),
		.rdata(mat_rdata)
	);

	minv4_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(ELEM_COUNT)
	) u_cof_ram (
		.clk  (clk),
		.we   (cof_we),
		.waddr({row_q, col_q}),
		.wdata(cof_wdata),
		.raddr(cof_raddr),
		.rdata(cof_rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			count_q     <= '0;
			row_q       <= '0;
			col_q       <= '0;
			term_q      <= '0;
			out_k_q     <= '0;
			div_cnt_q   <= '0;
			res_valid_q <= 1'b0;
		end else begin
			// result register: load a new result or drop one that transferred
			if (state_q == S_OUT && out_free) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && result_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_LOAD: begin
					if (in_xfer) begin
						count_q <= count_q + 1'b1;
						if (count_q == ELEM_AW'(ELEM_COUNT - 1)) begin
							row_q     <= '0;
							col_q     <= '0;
							term_q    <= '0;
							acc_q     <= '0;
							det_acc_q <= '0;
							state_q   <= S_RD_A;
						end
					end
				end
				S_RD_A: state_q <= S_RD_B;
				S_RD_B: begin
					x_q     <= mat_elem;
					state_q <= S_RD_C;
				end
				S_RD_C: begin
					y_q     <= mat_elem;
					state_q <= S_MUL1;
				end
				S_MUL1: begin
					z_q     <= mat_elem;
					p_q     <= mul_out;
					state_q <= S_MUL2;
				end
				S_MUL2: begin
					p_q     <= mul_out;
					state_q <= S_ACC;
				end
				S_ACC: begin
					// first three terms add, last three subtract
					if (term_q < 3'd3) begin
						acc_q <= acc_q + AW'($signed(p_q));
					end else begin
						acc_q <= acc_q - AW'($signed(p_q));
					end
					if (term_q == 3'd5) begin
						state_q <= S_COF;
					end else begin
						term_q  <= term_q + 3'd1;
						state_q <= S_RD_A;
					end
				end
				S_COF: begin
					cof_q  <= cof_wdata;
					acc_q  <= '0;
					term_q <= '0;
					if (row_q == 2'd0) begin
						state_q <= S_DRD;
					end else if (row_q == 2'd3 && col_q == 2'd3) begin
						state_q <= S_DET;
					end else begin
						{row_q, col_q} <= {row_q, col_q} + 4'd1;
						state_q        <= S_RD_A;
					end
				end
				S_DRD: state_q <= S_DLD;
				S_DLD: begin
					x_q     <= mat_elem;
					state_q <= S_DMUL;
				end
				S_DMUL: begin
					p_q     <= mul_out;
					state_q <= S_DACC;
				end
				S_DACC: begin
					det_acc_q      <= det_acc_q + EW'($signed(p_q));
					{row_q, col_q} <= {row_q, col_q} + 4'd1;
					state_q        <= S_RD_A;
				end
				S_DET: begin
					det_q   <= sat_dw(64'(det_acc_q));
					ud_q    <= det_acc_q[EW-1] ? DW'(-sat_dw(64'(det_acc_q)))
						: sat_dw(64'(det_acc_q));
					sing_q  <= (sat_dw(64'(det_acc_q)) == '0);
					out_k_q <= '0;
					state_q <= S_ORD;
				end
				S_ORD: state_q <= S_DSET;
				S_DSET: begin
					rem_q     <= '0;
					quo_q     <= '0;
					div_cnt_q <= '0;
					num_q     <= {cof_mag, {FRAC_BITS{1'b0}}};
					// singular matrix: skip the divide, emit zero
					neg_q     <= sing_q ? 1'b0 : (cof_rdata[DW-1] ^ det_q[DW-1]);
					state_q   <= sing_q ? S_OUT : S_DIV;
				end
				S_DIV: begin
					num_q <= num_q << 1;
					if (!rem_sub[DW]) begin
						rem_q <= rem_sub;
						quo_q <= {quo_q[NW-2:0], 1'b1};
					end else begin
						rem_q <= rem_shift;
						quo_q <= {quo_q[NW-2:0], 1'b0};
					end
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == CW'(NW - 1)) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						inv_q       <= neg_q ? 32'(-quo_sat[31:0]) : quo_sat[31:0];
						det32_q     <= sat_32(64'($signed(det_q)));
						sing_out_q  <= sing_q;
						last_q      <= (out_k_q == ELEM_AW'(ELEM_COUNT - 1));
						out_k_q     <= out_k_q + 1'b1;
						state_q     <= (out_k_q == ELEM_AW'(ELEM_COUNT - 1)) ? S_LOAD : S_ORD;
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	assign result_valid  = res_valid_q;
	assign inverse_value = inv_q;
	assign det_value     = det32_q;
	assign singular      = sing_out_q;
	assign last          = last_q;

endmodule
